/* rtl/sidechain_ducking_gain_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sidechain ducking gain block
// Short forms for clocked properties with reset disable on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef SIDECHAIN_DUCKING_GAIN_MACROS_SVH
`define SIDECHAIN_DUCKING_GAIN_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SCDG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SCDG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/scdg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdg_pkg
// Shared widths, constants, register indexes and types of the sidechain
// ducking gain block.
// ----------------------------------------------------------------------------
package scdg_pkg;

	// Field and register widths
	localparam int SAMPLE_W   = 16;
	localparam int THR_W      = 15;
	localparam int SCALE_W    = 24;
	localparam int COEFF_W    = 16;
	localparam int ENV_W      = 17;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = 18;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// 1.0 in Q1.16
	localparam logic [ENV_W-1:0] ENV_ONE = 17'h10000;

	// Register reset values
	localparam logic [THR_W-1:0]   THRESHOLD_RST = 15'd16384;
	localparam logic [SCALE_W-1:0] SCALE_RST     = 24'd524288;
	localparam logic [COEFF_W-1:0] ATTACK_RST    = 16'd65000;
	localparam logic [COEFF_W-1:0] RELEASE_RST   = 16'd65500;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd3;

	// Default depth of the queue between front and back (power of two, >= 2)
	localparam int QUEUE_DEPTH_DEF = 2;

	// Classified frame handed from front to back
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] audio_left;
		logic signed [SAMPLE_W-1:0] audio_right;
		logic [SAMPLE_W-1:0]        excess;
	} job_t;

	// Register values the back end works with
	typedef struct packed {
		logic [SCALE_W-1:0] above_scale;
		logic [COEFF_W-1:0] attack_coeff;
		logic [COEFF_W-1:0] release_coeff;
	} coeff_t;

endpackage

/* rtl/scdg_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdg_frame_if / scdg_result_if
// Valid/ready channels for stereo input frames and ducked output frames.
// ----------------------------------------------------------------------------
interface scdg_frame_if import scdg_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] audio_left;
	logic signed [SAMPLE_W-1:0] audio_right;
	logic signed [SAMPLE_W-1:0] side_left;
	logic signed [SAMPLE_W-1:0] side_right;

	modport source(output valid, audio_left, audio_right, side_left, side_right,
		input ready);
	modport sink(input valid, audio_left, audio_right, side_left, side_right,
		output ready);
endinterface

interface scdg_result_if import scdg_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_left;
	logic signed [SAMPLE_W-1:0] out_right;

	modport source(output valid, out_left, out_right, input ready);
	modport sink(input valid, out_left, out_right, output ready);
endinterface

/* rtl/sidechain_ducking_gain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidechain_ducking_gain
// Sidechain ducker: peak over threshold drives an attack/release envelope
// and both audio channels are scaled by one minus that envelope.
// ----------------------------------------------------------------------------
//  channel  | role   | handshake          | payload
//  frame    | sink   | valid / ready      | audio_left, audio_right, side_left, side_right
//  result   | source | valid / ready      | out_left, out_right
//  cfg      | write  | cfg_we, no wait    | cfg_index, cfg_data
//
//  Each frame passes through the back end in order: it is taken from the
//  queue in the idle state, then goes through eight sequencer steps around
//  the single shared 18x25 multiplier; the back end takes no new frame until
//  it returns to idle. The front queue holds QUEUE_DEPTH frames and the
//  output register one result, so input keeps being taken while a result
//  waits. Reset loads defaults and a zero envelope.
// ----------------------------------------------------------------------------
module sidechain_ducking_gain import scdg_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	scdg_frame_if.sink            frame,
	scdg_result_if.source         result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [THR_W-1:0]   threshold_q;
	logic [SCALE_W-1:0] scale_q;
	logic [COEFF_W-1:0] attack_q;
	logic [COEFF_W-1:0] release_q;
	coeff_t             coeff;
	job_t               job;
	logic               job_valid;
	logic               job_ready;

	// Register writes; excess data bits are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			scale_q     <= SCALE_RST;
			attack_q    <= ATTACK_RST;
			release_q   <= RELEASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_data[THR_W-1:0];
				REG_SCALE:     scale_q     <= cfg_data[SCALE_W-1:0];
				REG_ATTACK:    attack_q    <= cfg_data[COEFF_W-1:0];
				REG_RELEASE:   release_q   <= cfg_data[COEFF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign coeff.above_scale   = scale_q;
	assign coeff.attack_coeff  = attack_q;
	assign coeff.release_coeff = release_q;

	scdg_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame          (frame),
		.threshold_level(threshold_q),
		.job_valid      (job_valid),
		.job_ready      (job_ready),
		.job            (job)
	);

	scdg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job),
		.coeff    (coeff),
		.result   (result)
	);

endmodule

/* rtl/scdg_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdg_front
// Accepts stereo frames, reduces the sidechain to its excess over the
// threshold and queues the result with the audio for the back end.
// ----------------------------------------------------------------------------
module scdg_front import scdg_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	scdg_frame_if.sink       frame,
	input  logic [THR_W-1:0] threshold_level,
	output logic             job_valid,
	input  logic             job_ready,
	output job_t             job
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic [SAMPLE_W:0] mag_left;
	logic [SAMPLE_W:0] mag_right;
	logic [SAMPLE_W:0] peak;
	logic [SAMPLE_W:0] thr_ext;
	logic [SAMPLE_W:0] excess_wide;
	job_t              job_in;
	logic              push;
	logic              pop;

	// Take magnitudes; the most negative sample gives 1.0
	assign mag_left  = frame.side_left[SAMPLE_W-1]
		? (~{frame.side_left[SAMPLE_W-1], frame.side_left} + 1'b1)
		: {1'b0, frame.side_left};
	assign mag_right = frame.side_right[SAMPLE_W-1]
		? (~{frame.side_right[SAMPLE_W-1], frame.side_right} + 1'b1)
		: {1'b0, frame.side_right};

	// Peak over threshold, clamped at zero
	assign peak        = (mag_left > mag_right) ? mag_left : mag_right;
	assign thr_ext     = {2'b00, threshold_level};
	assign excess_wide = (peak > thr_ext) ? (peak - thr_ext) : '0;

	assign job_in.audio_left  = frame.audio_left;
	assign job_in.audio_right = frame.audio_right;
	assign job_in.excess      = excess_wide[SAMPLE_W-1:0];

	// Queue handshakes
	assign frame.ready = (count_q < CNT_W'(QUEUE_DEPTH));
	assign push        = frame.valid && frame.ready;
	assign job_valid   = (count_q != '0);
	assign pop         = job_valid && job_ready;
	assign job         = queue_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push)
			queue_q[wr_ptr_q] <= job_in;
	end

endmodule

/* rtl/scdg_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdg_back
// Sequences one shared multiplier through level scaling, the envelope
// update and the two gain products, then holds the result for the sink.
// ----------------------------------------------------------------------------
module scdg_back import scdg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  job_t        job,
	input  coeff_t      coeff,
	scdg_result_if.source result
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LVL_MUL,
		ST_LVL_SAT,
		ST_ENV_MUL0,
		ST_ENV_MUL1,
		ST_ENV_SUM,
		ST_OUT_MUL_L,
		ST_OUT_MUL_R,
		ST_RESULT
	} state_t;

	state_t                     state_q;
	job_t                       job_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic [ENV_W-1:0]           level_q;
	logic [COEFF_W-1:0]         c_q;
	logic [ENV_W-1:0]           env_q;
	logic [2*ENV_W-2:0]         acc_q;
	logic signed [SAMPLE_W-1:0] left_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_left_q;
	logic signed [SAMPLE_W-1:0] out_right_q;

	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic [PROD_W-1:0]          lvl_rnd;
	logic [PROD_W-14:0]         lvl_raw;
	logic [ENV_W-1:0]           level_next;
	logic [2*ENV_W-1:0]         env_sum;
	logic [ENV_W:0]             env_raw;
	logic [ENV_W-1:0]           env_next;
	logic [ENV_W-1:0]           gain;
	logic [ENV_W-1:0]           one_minus_c;
	logic signed [PROD_W-1:0]   out_rnd;
	logic                       out_free;

	assign job_ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || result.ready;

	assign result.valid     = out_valid_q;
	assign result.out_left  = out_left_q;
	assign result.out_right = out_right_q;

	// Level: round at bit 13, saturate at 1.0
	assign lvl_rnd    = prod_q + PROD_W'(4096);
	assign lvl_raw    = lvl_rnd[PROD_W-1:13];
	assign level_next = (lvl_raw > (PROD_W-13)'(ENV_ONE)) ? ENV_ONE : lvl_raw[ENV_W-1:0];

	// Envelope: sum both pole terms, round at bit 16, clamp at 1.0
	assign env_sum  = {1'b0, acc_q} + {1'b0, prod_q[2*ENV_W-2:0]} + (2*ENV_W)'(32768);
	assign env_raw  = env_sum[2*ENV_W-1:16];
	assign env_next = (env_raw > {1'b0, ENV_ONE}) ? ENV_ONE : env_raw[ENV_W-1:0];

	assign gain        = ENV_ONE - env_q;
	assign one_minus_c = ENV_ONE - {1'b0, c_q};

	// Output rounding: floor((p + 2^15) / 2^16), low 16 bits
	assign out_rnd = prod_q + PROD_W'(32768);

	// Select multiplier operands for the current step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_LVL_MUL: begin
				mul_a = {2'b00, job_q.excess};
				mul_b = {1'b0, coeff.above_scale};
			end
			ST_ENV_MUL0: begin
				mul_a = {2'b00, c_q};
				mul_b = {8'b0, env_q};
			end
			ST_ENV_MUL1: begin
				mul_a = {1'b0, one_minus_c};
				mul_b = {8'b0, level_q};
			end
			ST_OUT_MUL_L: begin
				mul_a = {{2{job_q.audio_left[SAMPLE_W-1]}}, job_q.audio_left};
				mul_b = {8'b0, gain};
			end
			ST_OUT_MUL_R: begin
				mul_a = {{2{job_q.audio_right[SAMPLE_W-1]}}, job_q.audio_right};
				mul_b = {8'b0, gain};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Sequencer, envelope state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			env_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new result when the register is free, drop it once taken
			if (state_q == ST_RESULT && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid)
						state_q <= ST_LVL_MUL;
				end
				ST_LVL_MUL: begin
					state_q <= ST_LVL_SAT;
				end
				ST_LVL_SAT: begin
					state_q <= ST_ENV_MUL0;
				end
				ST_ENV_MUL0: begin
					state_q <= ST_ENV_MUL1;
				end
				ST_ENV_MUL1: begin
					state_q <= ST_ENV_SUM;
				end
				ST_ENV_SUM: begin
					env_q   <= env_next;
					state_q <= ST_OUT_MUL_L;
				end
				ST_OUT_MUL_L: begin
					state_q <= ST_OUT_MUL_R;
				end
				ST_OUT_MUL_R: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid)
			job_q <= job;
		if (state_q != ST_RESULT && state_q != ST_IDLE)
			prod_q <= mul_p;
		if (state_q == ST_LVL_SAT) begin
			level_q <= level_next;
			c_q     <= (level_next > env_q) ? coeff.attack_coeff : coeff.release_coeff;
		end
		if (state_q == ST_ENV_MUL1)
			acc_q <= prod_q[2*ENV_W-2:0];
		if (state_q == ST_OUT_MUL_R)
			left_q <= out_rnd[SAMPLE_W+15:16];
		if (state_q == ST_RESULT && out_free) begin
			out_left_q  <= left_q;
			out_right_q <= out_rnd[SAMPLE_W+15:16];
		end
	end

endmodule

/* rtl/scdg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdg_checker
// Port-level checks of the ducker: result hold under stall, no result
// without an outstanding frame, and input stall once every slot is full.
// ----------------------------------------------------------------------------
`include "sidechain_ducking_gain_macros.svh"

module scdg_checker import scdg_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [SAMPLE_W-1:0] out_left,
	input logic signed [SAMPLE_W-1:0] out_right
);

	localparam int SLOTS  = QUEUE_DEPTH + 2;
	localparam int PEND_W = $clog2(SLOTS + 1);

	logic [PEND_W-1:0] pending_q;
	logic              in_take;
	logic              out_take;

	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	// Track frames accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_take && !out_take) begin
			pending_q <= pending_q + PEND_W'(1);
		end else if (out_take && !in_take) begin
			pending_q <= pending_q - PEND_W'(1);
		end
	end

	`SCDG_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(out_left) && $stable(out_right), "stalled result changed")
	`SCDG_ASSERT_NOW(a_no_orphan, out_valid, pending_q != '0, "result without an outstanding frame")
	`SCDG_ASSERT_NOW(a_full_stall, pending_q == PEND_W'(SLOTS), !in_ready, "frame taken with every slot full")

endmodule

bind sidechain_ducking_gain scdg_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_scdg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (frame.valid),
	.in_ready (frame.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_left (result.out_left),
	.out_right(result.out_right)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sidechain ducking gain block. Stereo frames go
// in over a valid/ready channel. A scoreboard class runs its own envelope
// follower on every accepted frame and compares each ducked result with the
// oldest expectation. The run steps through several register settings,
// extremes included, with random idling on both sides and one long output
// hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_top import scdg_pkg::*; ();

	localparam int     PERIOD_NS   = 10;
	localparam longint LIMIT_NS    = 4_000_000;
	localparam int     HOLD_CYCLES = 300;
	localparam longint UNITY       = ENV_ONE;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] audio_left;
		logic signed [SAMPLE_W-1:0] audio_right;
		logic signed [SAMPLE_W-1:0] side_left;
		logic signed [SAMPLE_W-1:0] side_right;
	} stereo_frame_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_left;
		logic signed [SAMPLE_W-1:0] out_right;
	} ducked_pair_t;

	typedef enum int {SIDE_QUIET, SIDE_LOUD, SIDE_ANY} side_level_t;

	// Envelope follower and store of pending ducked frames
	class duck_scoreboard;
		int           thr_level;
		int           above_scale;
		int           attack_c;
		int           release_c;
		longint       envelope;
		ducked_pair_t expected_q[$];
		int           errors;
		int           checked;
		int           full_ducks;
		int           rises;

		function void reset_state();
			thr_level   = int'(THRESHOLD_RST);
			above_scale = int'(SCALE_RST);
			attack_c    = int'(ATTACK_RST);
			release_c   = int'(RELEASE_RST);
			envelope    = 0;
		endfunction

		// Keep only the low bits that each register holds
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_THRESHOLD: thr_level   = int'(data[THR_W-1:0]);
				REG_SCALE:     above_scale = int'(data[SCALE_W-1:0]);
				REG_ATTACK:    attack_c    = int'(data[COEFF_W-1:0]);
				REG_RELEASE:   release_c   = int'(data[COEFF_W-1:0]);
				default: ;
			endcase
		endfunction

		function logic signed [SAMPLE_W-1:0] duck_sample(logic signed [SAMPLE_W-1:0] s,
				longint gain);
			longint v;
			v = (longint'(s) * gain + 32768) >>> 16;
			return v[SAMPLE_W-1:0];
		endfunction

		function void note_frame(stereo_frame_t f);
			longint       mag_l;
			longint       mag_r;
			longint       peak;
			longint       excess;
			longint       level;
			longint       coeff;
			longint       gain;
			ducked_pair_t p;
			mag_l = longint'(f.side_left);
			mag_r = longint'(f.side_right);
			if (mag_l < 0) mag_l = -mag_l;
			if (mag_r < 0) mag_r = -mag_r;
			peak   = (mag_l > mag_r) ? mag_l : mag_r;
			excess = (peak > thr_level) ? peak - thr_level : 0;
			// scale the excess, round and saturate at 1.0
			level = (excess * above_scale + 4096) >>> 13;
			if (level > UNITY) level = UNITY;
			// pick the pole by direction, then advance the envelope
			if (level > envelope) begin
				coeff = longint'(attack_c);
				rises++;
			end else begin
				coeff = longint'(release_c);
			end
			envelope = (coeff * envelope + (UNITY - coeff) * level + 32768) >>> 16;
			if (envelope > UNITY) envelope = UNITY;
			gain = UNITY - envelope;
			if (gain == 0) full_ducks++;
			p.out_left  = duck_sample(f.audio_left, gain);
			p.out_right = duck_sample(f.audio_right, gain);
			expected_q.push_back(p);
		endfunction

		function void check_result(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
			ducked_pair_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result item: out_left %0d out_right %0d", $time, l, r);
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (l !== e.out_left) begin
				errors++;
				$display("%0t: out_left mismatch: expected %0d actual %0d", $time, e.out_left, l);
			end
			if (r !== e.out_right) begin
				errors++;
				$display("%0t: out_right mismatch: expected %0d actual %0d", $time, e.out_right, r);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	scdg_frame_if  frame_if ();
	scdg_result_if result_if ();

	duck_scoreboard sb = new();
	bit             tx_idle_on;
	bit             rx_idle_on;
	bit             hold_req;
	int             n_settings;

	sidechain_ducking_gain i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(PERIOD_NS / 2) clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

	// Take result items, with random stalls and one long hold on request
	initial begin : result_sink
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_if.valid && result_if.ready)
				sb.check_result(result_if.out_left, result_if.out_right);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	function automatic stereo_frame_t frame_of(int al, int ar, int sl, int sr);
		stereo_frame_t f;
		f.audio_left  = SAMPLE_W'(al);
		f.audio_right = SAMPLE_W'(ar);
		f.side_left   = SAMPLE_W'(sl);
		f.side_right  = SAMPLE_W'(sr);
		return f;
	endfunction

	// Reciprocal of the headroom above the threshold, Q10.14, as software would set it
	function automatic int scale_for(int thr);
		longint s;
		s = (longint'(16384) * 32768) / (32768 - thr);
		if (s > 24'hFFFFFF) s = longint'(24'hFFFFFF);
		return int'(s);
	endfunction

	function automatic int rand_side(side_level_t lvl);
		int m;
		case (lvl)
			SIDE_QUIET: m = $urandom_range(0, 6000);
			SIDE_LOUD:  m = $urandom_range(12000, 32768);
			default:    return $urandom_range(0, 65535);
		endcase
		if ($urandom_range(0, 1) == 1) m = -m;
		return m;
	endfunction

	function automatic int rand_audio();
		if ($urandom_range(0, 15) == 0) begin
			case ($urandom_range(0, 3))
				0:       return -32768;
				1:       return 32767;
				2:       return 0;
				default: return -1;
			endcase
		end
		return $urandom_range(0, 65535);
	endfunction

	// Offer one item, with an optional gap first, and hold it until taken
	task automatic send_frame(stereo_frame_t f);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			frame_if.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		frame_if.valid       <= 1'b1;
		frame_if.audio_left  <= f.audio_left;
		frame_if.audio_right <= f.audio_right;
		frame_if.side_left   <= f.side_left;
		frame_if.side_right  <= f.side_right;
		do @(posedge clk); while (!frame_if.ready);
		sb.note_frame(f);
	endtask

	// Drop valid and wait until every ducked frame has come back
	task automatic close_phase();
		frame_if.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_settings(int thr, int scale, int att, int rel);
		logic [CFG_IDX_W-1:0]  regs [4];
		logic [CFG_DATA_W-1:0] vals [4];
		regs = '{REG_THRESHOLD, REG_SCALE, REG_ATTACK, REG_RELEASE};
		vals = '{CFG_DATA_W'(thr), CFG_DATA_W'(scale), CFG_DATA_W'(att), CFG_DATA_W'(rel)};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			sb.write_reg(regs[i], vals[i]);
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Runs of loud, quiet and arbitrary sidechain so the envelope climbs and decays
	task automatic random_frames(int count, bit with_hold);
		side_level_t lvl;
		int          run_left;
		lvl      = SIDE_ANY;
		run_left = 0;
		for (int k = 0; k < count; k++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(4, 60);
				case ($urandom_range(0, 9))
					0, 1, 2, 3: lvl = SIDE_LOUD;
					4, 5, 6:    lvl = SIDE_QUIET;
					default:    lvl = SIDE_ANY;
				endcase
			end
			run_left--;
			if (with_hold && k == count / 2) hold_req = 1'b1;
			send_frame(frame_of(rand_audio(), rand_audio(), rand_side(lvl), rand_side(lvl)));
		end
	endtask

	initial begin : stimulus
		int thr;
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= REG_THRESHOLD;
		cfg_data             <= '0;
		frame_if.valid       <= 1'b0;
		frame_if.audio_left  <= '0;
		frame_if.audio_right <= '0;
		frame_if.side_left   <= '0;
		frame_if.side_right  <= '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_req   = 1'b0;
		n_settings = 1;
		sb.reset_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: silence, threshold edge, full-scale peaks, decay
		send_frame(frame_of(0, 0, 0, 0));
		send_frame(frame_of(32767, -32768, 16384, -16384));
		send_frame(frame_of(-1, 1, 16385, 0));
		send_frame(frame_of(32767, -32768, -32768, 32767));
		send_frame(frame_of(-32768, 32767, 32767, -32768));
		send_frame(frame_of(21845, -21846, -32768, -32768));
		send_frame(frame_of(1, -1, 20000, -1000));
		send_frame(frame_of(-32768, 32767, 0, -5));
		send_frame(frame_of(32767, -32768, 100, 16000));
		send_frame(frame_of(12345, -12345, -16385, 16383));
		send_frame(frame_of(-2, 2, -17000, 17000));
		send_frame(frame_of(32767, 32767, 0, 0));
		close_phase();

		// Zero poles with junk above the register widths: envelope jumps to the level
		write_settings(24'hFF8000, 24'hFFFFFF, 24'hFF0000, 24'hAB0000);
		send_frame(frame_of(32767, -32768, -32768, 0));
		send_frame(frame_of(-32768, 32767, 0, 0));
		send_frame(frame_of(1000, -1000, 1, -1));
		send_frame(frame_of(-32768, 32767, 2, 3));
		send_frame(frame_of(32767, -1, 0, 8));
		send_frame(frame_of(16384, -16384, 0, 0));
		send_frame(frame_of(-1, 32767, 32767, 32767));
		send_frame(frame_of(-32768, -32768, 0, 1));
		close_phase();

		// Top threshold and slowest poles
		write_settings(32767, 24'hFFFFFF, 65535, 65535);
		random_frames(150, 1'b0);
		close_phase();

		thr = $urandom_range(0, 32767);
		write_settings(thr, scale_for(thr), $urandom_range(40000, 65535),
			$urandom_range(50000, 65535));
		random_frames(250, 1'b0);
		close_phase();

		// Fast poles; the output is held long enough to back the block up
		write_settings(8192, scale_for(8192), 2000, 20000);
		random_frames(250, 1'b1);
		close_phase();

		// Zero scale: the level never leaves zero
		write_settings(0, 0, $urandom_range(0, 65535), $urandom_range(0, 65535));
		random_frames(150, 1'b0);
		close_phase();

		write_settings($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
			$urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
		random_frames(220, 1'b0);
		close_phase();

		thr = $urandom_range(0, 32767);
		write_settings(thr, scale_for(thr), $urandom_range(0, 65535), $urandom_range(0, 65535));
		random_frames(220, 1'b0);
		close_phase();

		// Back to back to close the run
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		thr = $urandom_range(0, 32767);
		write_settings(thr, scale_for(thr), $urandom_range(30000, 65535),
			$urandom_range(30000, 65535));
		random_frames(210, 1'b0);
		close_phase();
		repeat (20) @(posedge clk);

		$display("Checked %0d ducked frames over %0d register settings, extremes included",
			sb.checked, n_settings);
		$display("Envelope rose on %0d frames and the gain reached zero on %0d frames",
			sb.rises, sb.full_ducks);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
